>>> src/rtt_pkg.sv
package rtt_pkg;

   // Payload bytes that a send timestamp occupies; a longer payload carries one.
   localparam int unsigned TIMESTAMP_BYTES = 16;

   localparam int unsigned TIME_W   = 48;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned RTT_W    = 32;
   localparam int unsigned MEAN_W   = 48;
   localparam int unsigned SQ_W     = 64;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned FRAC_W   = 16;

   typedef struct packed {
      logic [TIME_W-1:0] sent_time_us;
      logic [TIME_W-1:0] arrival_time_us;
      logic [LEN_W-1:0]  payload_length;
   } req_type;

   typedef struct packed {
      logic               sample_used;
      logic [RTT_W-1:0]   rtt_us;
      logic [RTT_W-1:0]   min_rtt_us;
      logic [RTT_W-1:0]   max_rtt_us;
      logic [MEAN_W-1:0]  mean_rtt_q16;
      logic [SQ_W-1:0]    variance_us2;
      logic [COUNT_W-1:0] samples_timed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RTT,
      ST_DIFF,
      ST_DSTART,
      ST_DWAIT,
      ST_MEAN,
      ST_DNEW,
      ST_MUL,
      ST_ACC,
      ST_SQ,
      ST_VSTART,
      ST_VWAIT,
      ST_VAR,
      ST_RESP
   } rtt_state_type;

   // Partial products of the 48 x 48 deviation product, high and low halves.
   typedef enum logic [1:0] {
      TERM_HH,
      TERM_HL,
      TERM_LH,
      TERM_LL
   } rtt_term_type;

   typedef struct packed {
      logic         load_req;
      logic         calc_rtt;
      logic         calc_diff;
      logic         div_start;
      logic         div_var;
      logic         mean_upd;
      logic         dnew_upd;
      logic         mul_en;
      logic         acc_en;
      rtt_term_type term;
      logic         sq_upd;
      logic         var_upd;
      logic         rsp_load;
   } rtt_cmd_type;

   typedef struct packed {
      logic used;
      logic div_done;
      logic rsp_free;
   } rtt_sts_type;

endpackage

>>> src/rtt_div.sv
module rtt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;

   logic [32:0] t0, t1;
   logic [31:0] r0;
   logic        b0, b1;

   // Restoring division, two quotient bits per cycle.
   always_comb begin
      t0 = {rem_ff, quo_ff[63]};
      b0 = (t0 >= {1'b0, dvs_ff});
      r0 = b0 ? 32'(t0 - {1'b0, dvs_ff}) : t0[31:0];
      t1 = {r0, quo_ff[62]};
      b1 = (t1 >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = b1 ? 32'(t1 - {1'b0, dvs_ff}) : t1[31:0];
         quo_in = {quo_ff[61:0], b0, b1};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // The final step runs in the cycle that done is high; the quotient follows.
   assign done     = busy_ff && (cnt_ff == 5'd31);
   assign quotient = quo_ff;

endmodule

>>> src/rtt_dp.sv
module rtt_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rtt_pkg::rtt_cmd_type cmd,
   output rtt_pkg::rtt_sts_type sts,
   input  rtt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtt_pkg::rsp_type     rsp_data
);

   rtt_pkg::req_type req_ff;

   logic                         used_ff;
   logic [rtt_pkg::RTT_W-1:0]    rtt_ff, rtt_in;
   logic [rtt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rtt_pkg::RTT_W-1:0]    min_ff, min_in;
   logic [rtt_pkg::RTT_W-1:0]    max_ff, max_in;
   logic [rtt_pkg::MEAN_W-1:0]   mean_ff, mean_in;
   logic [rtt_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [rtt_pkg::SQ_W-1:0]     var_ff;
   logic                         up_ff;
   logic [rtt_pkg::MEAN_W-1:0]   dold_ff, dnew_ff, dold_in, dnew_in;
   logic [63:0]                  prod_ff, acc_ff, acc_term;
   logic [31:0]                  mul_a, mul_b;
   logic                         rsp_valid_ff;
   rtt_pkg::rsp_type             rsp_ff;

   logic                         used;
   logic [rtt_pkg::TIME_W-1:0]   span;
   logic [rtt_pkg::MEAN_W-1:0]   x;
   logic                         up;
   logic [64:0]                  sq_sum;
   logic [63:0]                  div_dividend;
   logic                         div_done;
   logic [63:0]                  div_quo;

   assign used = (req_ff.payload_length > rtt_pkg::LEN_W'(rtt_pkg::TIMESTAMP_BYTES));
   assign x    = {rtt_ff, {rtt_pkg::FRAC_W{1'b0}}};
   assign up   = (x >= mean_ff);

   always_comb begin
      // Arrival before send gives zero; a span beyond 32 bits saturates.
      span     = (req_ff.arrival_time_us > req_ff.sent_time_us) ?
                 (req_ff.arrival_time_us - req_ff.sent_time_us) : '0;
      rtt_in   = (span[rtt_pkg::TIME_W-1:rtt_pkg::RTT_W] != '0) ? '1 :
                 span[rtt_pkg::RTT_W-1:0];
      count_in = (count_ff == '1) ? count_ff : count_ff + rtt_pkg::COUNT_W'(1);
      max_in   = (rtt_in > max_ff) ? rtt_in : max_ff;
      min_in   = ((rtt_in < min_ff) || (count_ff == '0)) ? rtt_in : min_ff;
   end

   always_comb begin
      dold_in = up ? (x - mean_ff) : (mean_ff - x);
      dnew_in = up_ff ? (x - mean_ff) : (mean_ff - x);
      mean_in = up_ff ? (mean_ff + div_quo[rtt_pkg::MEAN_W-1:0]) :
                        (mean_ff - div_quo[rtt_pkg::MEAN_W-1:0]);
   end

   // One 32 x 32 multiplier walks the four partial products of dold * dnew.
   always_comb begin
      unique case (cmd.term)
         rtt_pkg::TERM_HH: begin
            mul_a    = {16'd0, dold_ff[47:32]};
            mul_b    = {16'd0, dnew_ff[47:32]};
            acc_term = {prod_ff[31:0], 32'd0};
         end
         rtt_pkg::TERM_HL: begin
            mul_a    = {16'd0, dold_ff[47:32]};
            mul_b    = dnew_ff[31:0];
            acc_term = prod_ff;
         end
         rtt_pkg::TERM_LH: begin
            mul_a    = dold_ff[31:0];
            mul_b    = {16'd0, dnew_ff[47:32]};
            acc_term = prod_ff;
         end
         default: begin
            mul_a    = dold_ff[31:0];
            mul_b    = dnew_ff[31:0];
            acc_term = {32'd0, prod_ff[63:32]};
         end
      endcase
   end

   assign sq_sum = {1'b0, sq_ff} + {1'b0, acc_ff};
   assign sq_in  = sq_sum[64] ? '1 : sq_sum[63:0];

   assign div_dividend = cmd.div_var ? sq_ff :
                         {{(64 - rtt_pkg::MEAN_W){1'b0}}, dold_ff};

   rtt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         mean_ff  <= '0;
         sq_ff    <= '0;
         var_ff   <= '0;
      end else begin
         if (cmd.calc_rtt && used) begin
            count_ff <= count_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
         if (cmd.mean_upd) begin
            mean_ff <= mean_in;
         end
         if (cmd.sq_upd) begin
            sq_ff <= sq_in;
         end
         if (cmd.var_upd) begin
            var_ff <= div_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.calc_rtt) begin
         used_ff <= used;
         rtt_ff  <= used ? rtt_in : '0;
      end
      if (cmd.calc_diff) begin
         up_ff   <= up;
         dold_ff <= dold_in;
      end
      if (cmd.dnew_upd) begin
         dnew_ff <= dnew_in;
         acc_ff  <= '0;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_ff + acc_term;
      end
   end

   // Output register: a finished result waits here until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff.sample_used   <= used_ff;
         rsp_ff.rtt_us        <= rtt_ff;
         rsp_ff.min_rtt_us    <= min_ff;
         rsp_ff.max_rtt_us    <= max_ff;
         rsp_ff.mean_rtt_q16  <= mean_ff;
         rsp_ff.variance_us2  <= var_ff;
         rsp_ff.samples_timed <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.used     = used;
   assign sts.div_done = div_done;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule

>>> src/rtt_ctrl.sv
module rtt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rtt_pkg::rtt_sts_type sts,
   output rtt_pkg::rtt_cmd_type cmd
);

   rtt_pkg::rtt_state_type state_ff, state_in;
   rtt_pkg::rtt_term_type  term_ff, term_in;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         rtt_pkg::ST_IDLE:   if (req_valid) state_in = rtt_pkg::ST_RTT;
         rtt_pkg::ST_RTT:    state_in = sts.used ? rtt_pkg::ST_DIFF : rtt_pkg::ST_RESP;
         rtt_pkg::ST_DIFF:   state_in = rtt_pkg::ST_DSTART;
         rtt_pkg::ST_DSTART: state_in = rtt_pkg::ST_DWAIT;
         rtt_pkg::ST_DWAIT:  if (sts.div_done) state_in = rtt_pkg::ST_MEAN;
         rtt_pkg::ST_MEAN:   state_in = rtt_pkg::ST_DNEW;
         rtt_pkg::ST_DNEW: begin
            state_in = rtt_pkg::ST_MUL;
            term_in  = rtt_pkg::TERM_HH;
         end
         rtt_pkg::ST_MUL:    state_in = rtt_pkg::ST_ACC;
         rtt_pkg::ST_ACC: begin
            if (term_ff == rtt_pkg::TERM_LL) begin
               state_in = rtt_pkg::ST_SQ;
            end else begin
               state_in = rtt_pkg::ST_MUL;
               term_in  = rtt_pkg::rtt_term_type'(term_ff + 2'd1);
            end
         end
         rtt_pkg::ST_SQ:     state_in = rtt_pkg::ST_VSTART;
         rtt_pkg::ST_VSTART: state_in = rtt_pkg::ST_VWAIT;
         rtt_pkg::ST_VWAIT:  if (sts.div_done) state_in = rtt_pkg::ST_VAR;
         rtt_pkg::ST_VAR:    state_in = rtt_pkg::ST_RESP;
         rtt_pkg::ST_RESP:   if (sts.rsp_free) state_in = rtt_pkg::ST_IDLE;
         default:            state_in = rtt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.term  = term_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         rtt_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         rtt_pkg::ST_RTT:    cmd.calc_rtt  = 1'b1;
         rtt_pkg::ST_DIFF:   cmd.calc_diff = 1'b1;
         rtt_pkg::ST_DSTART: cmd.div_start = 1'b1;
         rtt_pkg::ST_DWAIT:  cmd.div_var   = 1'b0;
         rtt_pkg::ST_MEAN:   cmd.mean_upd  = 1'b1;
         rtt_pkg::ST_DNEW:   cmd.dnew_upd  = 1'b1;
         rtt_pkg::ST_MUL:    cmd.mul_en    = 1'b1;
         rtt_pkg::ST_ACC:    cmd.acc_en    = 1'b1;
         rtt_pkg::ST_SQ:     cmd.sq_upd    = 1'b1;
         rtt_pkg::ST_VSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_var   = 1'b1;
         end
         rtt_pkg::ST_VWAIT:  cmd.div_var   = 1'b1;
         rtt_pkg::ST_VAR:    cmd.var_upd   = 1'b1;
         rtt_pkg::ST_RESP:   cmd.rsp_load  = sts.rsp_free;
         default:            cmd.load_req  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtt_pkg::ST_IDLE;
         term_ff  <= rtt_pkg::TERM_HH;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

endmodule

>>> src/rtt_running_statistics_top.sv
// Round-trip time statistics for ping replies.
// The req_ channel carries one reply per transaction: send timestamp, arrival
// time and payload length. The rsp_ channel returns exactly one result per
// reply: the reply's round-trip time, minimum, maximum, running mean (Q32.16),
// population variance and the count of timed samples.
// A reply whose payload is no longer than a timestamp leaves the statistics
// alone; it goes from the RTT state straight to the RESP state and on to the
// output register.
// A timed reply takes two passes through the shared 64 / 32 bit divider (two
// quotient bits per cycle) for the mean step and the variance, plus four
// partial products on one 32 x 32 multiplier for the squared-deviation update.
// One reply is worked on at a time; req_ready is high only while the block is
// idle. The result sits in an output register, so a new reply is accepted
// while the previous result still waits; if the receiver stalls, the next
// result waits in the controller until the register frees up.
// Synchronous reset clears all statistics to zero and drops any pending result.
module rtt_running_statistics_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rtt_pkg::rsp_type rsp_data
);

   rtt_pkg::rtt_cmd_type cmd;
   rtt_pkg::rtt_sts_type sts;

   rtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/rtt_chk.sv
module rtt_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rtt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rtt_pkg::rsp_type rsp_data
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Only one reply is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second reply accepted while busy");

   // A reply without a timestamp reports no round-trip time.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sample_used |-> rsp_data.rtt_us == '0)
      else $error("unused reply reports a round-trip time");

   // A timed sample lies between the minimum and the maximum, and the count is nonzero.
   a_used_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_used |->
         rsp_data.samples_timed != '0 &&
         rsp_data.min_rtt_us <= rsp_data.rtt_us &&
         rsp_data.rtt_us <= rsp_data.max_rtt_us)
      else $error("timed sample outside min/max or count is zero");

   // Before any timed sample the mean and the variance read zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.samples_timed == '0 |->
         rsp_data.variance_us2 == '0 && rsp_data.mean_rtt_q16 == '0)
      else $error("statistics nonzero with no samples");

endmodule

bind rtt_running_statistics_top rtt_chk u_rtt_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/rtt_stats_checker.sv
module rtt_stats_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rtt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rtt_pkg::rsp_type rsp_data,
   output int unsigned      mismatches,
   output int unsigned      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SHOWN_MISMATCHES = 10;

   // Running statistics as the block should hold them.
   logic [rtt_pkg::COUNT_W-1:0] n_timed;
   logic [rtt_pkg::RTT_W-1:0]   lowest_rtt;
   logic [rtt_pkg::RTT_W-1:0]   highest_rtt;
   logic [rtt_pkg::MEAN_W-1:0]  mean_q16;
   logic [rtt_pkg::SQ_W-1:0]    sq_dev_sum;

   rtt_pkg::rsp_type expected_stats[$];

   // Folds one reply into the running statistics and returns the result
   // that the block must report for it.
   function automatic rtt_pkg::rsp_type fold_reply(rtt_pkg::req_type reply);
      rtt_pkg::rsp_type          stats;
      logic                      used;
      logic                      rising;
      logic [47:0]               span;
      logic [rtt_pkg::RTT_W-1:0] rtt;
      logic [63:0]               x_q16;
      logic [63:0]               mean_ext;
      logic [63:0]               d_old;
      logic [63:0]               d_new;
      logic [63:0]               step;
      logic [63:0]               prod;
      logic [95:0]               full_prod;

      used = reply.payload_length > rtt_pkg::TIMESTAMP_BYTES;
      rtt  = '0;
      if (used) begin
         if (n_timed != '1) begin
            n_timed = n_timed + rtt_pkg::COUNT_W'(1);
         end
         if (reply.arrival_time_us > reply.sent_time_us) begin
            span = reply.arrival_time_us - reply.sent_time_us;
            rtt  = (span > 48'h0000_FFFF_FFFF) ? '1 : span[rtt_pkg::RTT_W-1:0];
         end
         if (rtt > highest_rtt) begin
            highest_rtt = rtt;
         end
         // The first timed sample replaces the reset minimum of zero.
         if (rtt < lowest_rtt || n_timed == 1) begin
            lowest_rtt = rtt;
         end

         x_q16    = {16'b0, rtt, 16'b0};
         mean_ext = {16'b0, mean_q16};
         rising   = x_q16 >= mean_ext;
         d_old    = rising ? x_q16 - mean_ext : mean_ext - x_q16;
         step     = d_old / n_timed;
         mean_ext = rising ? mean_ext + step : mean_ext - step;
         mean_q16 = mean_ext[rtt_pkg::MEAN_W-1:0];
         mean_ext = {16'b0, mean_q16};
         d_new    = rising ? x_q16 - mean_ext : mean_ext - x_q16;

         full_prod = {32'b0, d_old} * {32'b0, d_new};
         prod      = full_prod[95:32];
         if (sq_dev_sum > 64'hFFFF_FFFF_FFFF_FFFF - prod) begin
            sq_dev_sum = '1;
         end else begin
            sq_dev_sum = sq_dev_sum + prod;
         end
      end

      stats.sample_used   = used;
      stats.rtt_us        = rtt;
      stats.min_rtt_us    = lowest_rtt;
      stats.max_rtt_us    = highest_rtt;
      stats.mean_rtt_q16  = mean_q16;
      stats.variance_us2  = (n_timed != 0) ? sq_dev_sum / n_timed : '0;
      stats.samples_timed = n_timed;
      return stats;
   endfunction

   function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         if (mismatches < SHOWN_MISMATCHES) begin
            $display("%t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
         end
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rtt_pkg::rsp_type want;

      if (reset) begin
         n_timed     = '0;
         lowest_rtt  = '0;
         highest_rtt = '0;
         mean_q16    = '0;
         sq_dev_sum  = '0;
         mismatches  = 0;
         expected_stats.delete();
         outstanding <= 0;
      end else begin
         // A result can never belong to the transaction accepted at the same
         // edge, so the result side is handled first.
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               if (mismatches < SHOWN_MISMATCHES) begin
                  $display("%t: result with nothing expected, actual %h", $realtime, rsp_data);
               end
               mismatches++;
            end else begin
               want = expected_stats.pop_front();
               compare_field("sample_used", want.sample_used, rsp_data.sample_used);
               compare_field("rtt_us", want.rtt_us, rsp_data.rtt_us);
               compare_field("min_rtt_us", want.min_rtt_us, rsp_data.min_rtt_us);
               compare_field("max_rtt_us", want.max_rtt_us, rsp_data.max_rtt_us);
               compare_field("mean_rtt_q16", want.mean_rtt_q16, rsp_data.mean_rtt_q16);
               compare_field("variance_us2", want.variance_us2, rsp_data.variance_us2);
               compare_field("samples_timed", want.samples_timed, rsp_data.samples_timed);
            end
         end
         if (req_valid && req_ready) begin
            expected_stats.push_back(fold_reply(req_data));
         end
         outstanding <= expected_stats.size();
      end
   end

endmodule

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REPLIES = 1330;
   localparam int unsigned DRAIN_CYCLES   = 100;
   localparam int unsigned HOLD_CYCLES    = 600;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rtt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rtt_pkg::rsp_type rsp_data;
   logic             rsp_hold;
   logic             sender_eager;
   int unsigned      mismatches;
   int unsigned      outstanding;
   int unsigned      replies_offered;
   int unsigned      results_taken;

   rtt_running_statistics_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rtt_stats_checker stats_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rtt_pkg::req_type reply(logic [47:0] sent, logic [47:0] arrived,
                                              logic [15:0] len);
      rtt_pkg::req_type item;
      item.sent_time_us    = sent;
      item.arrival_time_us = arrived;
      item.payload_length  = len;
      return item;
   endfunction

   // Mostly realistic round trips from random send times, a few replies
   // that arrive before they were sent, and some short payloads.
   function automatic rtt_pkg::req_type random_reply();
      logic [63:0] word;
      logic [47:0] sent;
      logic [47:0] delta;
      logic [15:0] len;
      word  = {$urandom, $urandom};
      sent  = word[47:0];
      delta = ($urandom_range(0, 4) == 0) ? 48'($urandom_range(0, 1 << 24)) :
                                            48'($urandom_range(0, 4000));
      if ($urandom_range(0, 6) == 0) begin
         len = 16'($urandom_range(0, rtt_pkg::TIMESTAMP_BYTES));
      end else begin
         len = 16'($urandom_range(rtt_pkg::TIMESTAMP_BYTES + 1, 16'hFFFF));
      end
      if ($urandom_range(0, 49) == 0) begin
         return reply(sent, sent - delta - 48'd1, len);
      end
      return reply(sent, sent + delta, len);
   endfunction

   task automatic offer(input rtt_pkg::req_type item);
      int unsigned gap;
      gap = sender_eager ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      replies_offered++;
   endtask

   // Receiver: random stalls, stretches of constant readiness, and long
   // hold-offs requested by the process below.
   initial begin
      int unsigned gap;
      rsp_ready     <= 1'b0;
      results_taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = ((results_taken / 64) % 4 == 2) ? 0 : $urandom_range(0, 18);
         if (gap != 0 || rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            do @(posedge clock); while (rsp_hold);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         results_taken++;
      end
   end

   // Holding the result side off long enough lets the block fill up and
   // stall the request side while the sender keeps offering.
   initial begin
      rsp_hold <= 1'b0;
      wait (replies_offered >= 350);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
      wait (replies_offered >= 1000);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data        <= '0;
      sender_eager    = 1'b0;
      replies_offered = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Short payloads before any sample, the length boundary, the first
      // sample setting the minimum, and timestamps with wide bit patterns.
      offer(reply(48'h0, 48'h0, 16'd0));
      offer(reply(48'd100, 48'd900, 16'(rtt_pkg::TIMESTAMP_BYTES)));
      offer(reply(48'd1000, 48'd1250, 16'(rtt_pkg::TIMESTAMP_BYTES + 1)));
      offer(reply(48'd2000, 48'd2100, 16'hFFFF));
      offer(reply(48'd3000, 48'd8000, 16'h8000));
      offer(reply(48'd50, 48'd60, 16'd1));
      offer(reply(48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0309, 16'h7FFF));
      offer(reply(48'h5555_5555_5555, 48'h5555_5555_5558, 16'h00FF));
      offer(reply(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAC_CC6A, 16'h0F00));
      offer(reply(48'h0000_FFFF_0000, 48'h0000_FFFF_0001, 16'h5555));
      offer(reply(48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 16'hAAAA));

      for (int unsigned i = 0; i < RANDOM_REPLIES; i++) begin
         sender_eager = (i / 64) % 4 == 1;
         if (i == 700) begin
            // Let the block drain completely before going on.
            req_valid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         offer(random_reply());
      end
      sender_eager = 1'b0;

      // Extreme round trips last, since they saturate the squared deviation
      // sum for the rest of the run.
      offer(reply(48'h0, 48'h0000_FFFF_FFFF, 16'(rtt_pkg::TIMESTAMP_BYTES + 1)));
      offer(reply(48'h0, 48'h0001_0000_0000, 16'hFFFF));
      offer(reply(48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF));
      offer(reply(48'hFFFF_FFFF_FFFF, 48'h0, 16'(rtt_pkg::TIMESTAMP_BYTES + 1)));
      offer(reply(48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF));
      offer(reply(48'h8000_0000_0000, 48'h8000_0000_0000, 16'd20));
      offer(reply(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0));
      offer(reply(48'd10, 48'd20, 16'(rtt_pkg::TIMESTAMP_BYTES)));
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
src/rtt_pkg.sv
src/rtt_div.sv
src/rtt_dp.sv
src/rtt_ctrl.sv
src/rtt_running_statistics_top.sv
src/rtt_chk.sv
verif/rtt_stats_checker.sv
verif/tb.sv
